FILE: design/slru_pkg.sv
// ----------------------------------------------------------------------------
// slru_pkg
// Shared constants, codes and types of the segmented LRU replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package slru_pkg;

   // default geometry
   localparam int MAX_SEGMENTS_DEF        = 4;
   localparam int ENTRIES_PER_SEGMENT_DEF = 64;
   localparam int KEY_BITS_DEF            = 32;
   localparam int SIZE_BITS_DEF           = 16;

   // fixed field widths
   localparam int USED_W      = 33;
   localparam int DROP_W      = 9;
   localparam int META_W      = 5;
   localparam int ACT_W       = 3;
   localparam int SEGB_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 16;
   localparam int ID_W        = 32;
   localparam int OSIZE_W     = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_BYTES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_METADATA_BYTES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SEGMENTS = 2'd2;

   // register reset values
   localparam logic [SEGB_W-1:0] SEGMENT_BYTES_RST   = 32'd65536;
   localparam logic [META_W-1:0] METADATA_BYTES_RST  = 5'd0;
   localparam logic [ACT_W-1:0]  ACTIVE_SEGMENTS_RST = 3'd4;

   // request kinds
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UNL_RD,
      ST_UNL_WR,
      ST_CHECK,
      ST_EVICT,
      ST_FIT,
      ST_FIT0,
      ST_DONE
   } slru_state_type;

   // what follows an unlink
   typedef enum logic [2:0] {
      CTX_REMOVE,
      CTX_PROMOTE,
      CTX_COOL,
      CTX_EVICT,
      CTX_FIT0
   } slru_ctx_type;

   // write enables of the entry store
   typedef struct packed {
      logic ent_we;
      logic older_we;
      logic newer_we;
   } slru_mem_ctl_type;

endpackage

`default_nettype wire

FILE: design/slru_entry_store.sv
// ----------------------------------------------------------------------------
// slru_entry_store
// Entry memories: key, size, segment and the two list links of each slot.
// ----------------------------------------------------------------------------
`default_nettype none

module slru_entry_store #(
   parameter int NUM_ENTRIES = 256,
   parameter int IDX_W       = 8,
   parameter int KEY_BITS    = 32,
   parameter int SIZE_BITS   = 16,
   parameter int SEG_W       = 2
) (
   input  wire                            clock,
   input  wire slru_pkg::slru_mem_ctl_type ctl,
   input  wire  [IDX_W-1:0]               rd_addr,
   input  wire  [IDX_W-1:0]               ent_addr,
   input  wire  [KEY_BITS-1:0]            ent_key,
   input  wire  [SIZE_BITS-1:0]           ent_size,
   input  wire  [SEG_W-1:0]               ent_seg,
   input  wire  [IDX_W-1:0]               older_addr,
   input  wire  [IDX_W-1:0]               older_data,
   input  wire  [IDX_W-1:0]               newer_addr,
   input  wire  [IDX_W-1:0]               newer_data,
   output logic [KEY_BITS-1:0]            rd_key,
   output logic [SIZE_BITS-1:0]           rd_size,
   output logic [SEG_W-1:0]               rd_seg,
   output logic [IDX_W-1:0]               rd_older,
   output logic [IDX_W-1:0]               rd_newer
);

   logic [KEY_BITS-1:0]  key_mem   [NUM_ENTRIES];
   logic [SIZE_BITS-1:0] size_mem  [NUM_ENTRIES];
   logic [SEG_W-1:0]     seg_mem   [NUM_ENTRIES];
   logic [IDX_W-1:0]     older_mem [NUM_ENTRIES];
   logic [IDX_W-1:0]     newer_mem [NUM_ENTRIES];

   always_ff @(posedge clock) begin
      if (ctl.ent_we) begin
         key_mem[ent_addr]  <= ent_key;
         size_mem[ent_addr] <= ent_size;
         seg_mem[ent_addr]  <= ent_seg;
      end
      rd_key  <= key_mem[rd_addr];
      rd_size <= size_mem[rd_addr];
      rd_seg  <= seg_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.older_we) begin
         older_mem[older_addr] <= older_data;
      end
      rd_older <= older_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.newer_we) begin
         newer_mem[newer_addr] <= newer_data;
      end
      rd_newer <= newer_mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: design/segmented_lru_replacement.sv
// A lookup scans the slots one per cycle until it finds the key or passes the last
// slot; each unlink then reads the entry and afterwards writes its links, and each
// link or fit check is done in its own state; the scan through the entry memory read port dominates.
// One item is in work at a time; the result sits in an output register.
// Reset: registers take their defaults and the cache is empty. Any
// configuration write also empties the cache at once.
// ----------------------------------------------------------------------------
// segmented_lru_replacement
// Segmented LRU with byte-limited segments, promotion, cooling cascade and
// eviction, kept as per-segment doubly linked lists in an entry memory.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_lru_replacement #(
   parameter int MAX_SEGMENTS        = slru_pkg::MAX_SEGMENTS_DEF,
   parameter int ENTRIES_PER_SEGMENT = slru_pkg::ENTRIES_PER_SEGMENT_DEF,
   parameter int KEY_BITS            = slru_pkg::KEY_BITS_DEF,
   parameter int SIZE_BITS           = slru_pkg::SIZE_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // object_id [31:0], object_size [47:32]
   input  wire  [slru_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation [0]
   input  wire  [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // hit [0], hit_segment [2:1], inserted [3], insert_segment [5:4],
   // evicted_count [14:6], too_large [15]
   output logic [slru_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [slru_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [slru_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int N      = MAX_SEGMENTS * ENTRIES_PER_SEGMENT;
   localparam int IDX_W  = $clog2(N);
   localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int NSEG_W = $clog2(MAX_SEGMENTS + 1);
   localparam int CNT_W  = $clog2(ENTRIES_PER_SEGMENT + 1);
   localparam int CHG_W  = ((SIZE_BITS > slru_pkg::META_W) ? SIZE_BITS : slru_pkg::META_W) + 1;
   localparam int USED_W = slru_pkg::USED_W;
   localparam int TOT_W  = USED_W + 3;
   localparam int CMP_W  = TOT_W + 1;

   // config
   logic [slru_pkg::SEGB_W-1:0] segb_ff, segb_in;
   logic [slru_pkg::META_W-1:0] meta_ff, meta_in;
   logic [slru_pkg::ACT_W-1:0]  act_ff, act_in;

   slru_pkg::slru_state_type state_ff, state_in;
   slru_pkg::slru_ctx_type   ctx_ff, ctx_in;

   logic                  op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [SIZE_BITS-1:0]  size_ff, size_in;
   logic [CHG_W-1:0]      chg_ff, chg_in;
   logic [TOT_W-1:0]      cap_ff, cap_in;
   logic [IDX_W:0]        scan_ff, scan_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]      cmp_addr_ff, cmp_addr_in;
   logic [IDX_W-1:0]      free_ff, free_in;
   logic                  hit_ff, hit_in;
   logic [SEG_W-1:0]      hit_seg_ff, hit_seg_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic                  ins_ff, ins_in;
   logic [SEG_W-1:0]      ins_seg_ff, ins_seg_in;
   logic                  big_ff, big_in;
   logic [slru_pkg::DROP_W-1:0] drop_ff, drop_in;
   logic [SEG_W-1:0]      seg_ff, seg_in;
   logic [SEG_W-1:0]      base_ff, base_in;
   logic [IDX_W-1:0]      u_ff, u_in;

   logic [CNT_W-1:0]      cnt_ff  [MAX_SEGMENTS];
   logic [CNT_W-1:0]      cnt_in  [MAX_SEGMENTS];
   logic [USED_W-1:0]     used_ff [MAX_SEGMENTS];
   logic [USED_W-1:0]     used_in [MAX_SEGMENTS];
   logic [IDX_W-1:0]      lru_ff  [MAX_SEGMENTS];
   logic [IDX_W-1:0]      lru_in  [MAX_SEGMENTS];
   logic [IDX_W-1:0]      mru_ff  [MAX_SEGMENTS];
   logic [IDX_W-1:0]      mru_in  [MAX_SEGMENTS];
   logic [TOT_W-1:0]      total_ff, total_in;
   logic [N-1:0]          valid_ff, valid_in;

   // object carried down to each segment level during a cascade
   logic [IDX_W-1:0]      cslot_ff [MAX_SEGMENTS];
   logic [IDX_W-1:0]      cslot_in [MAX_SEGMENTS];
   logic [KEY_BITS-1:0]   ckey_ff  [MAX_SEGMENTS];
   logic [KEY_BITS-1:0]   ckey_in  [MAX_SEGMENTS];
   logic [SIZE_BITS-1:0]  csize_ff [MAX_SEGMENTS];
   logic [SIZE_BITS-1:0]  csize_in [MAX_SEGMENTS];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [slru_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // entry store
   slru_pkg::slru_mem_ctl_type mem_ctl;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      ent_addr;
   logic [KEY_BITS-1:0]   ent_key;
   logic [SIZE_BITS-1:0]  ent_size;
   logic [SEG_W-1:0]      ent_seg;
   logic [IDX_W-1:0]      older_addr, older_data, newer_addr, newer_data;
   logic [KEY_BITS-1:0]   rd_key;
   logic [SIZE_BITS-1:0]  rd_size;
   logic [SEG_W-1:0]      rd_seg;
   logic [IDX_W-1:0]      rd_older, rd_newer;

   slru_entry_store #(
      .NUM_ENTRIES (N),
      .IDX_W       (IDX_W),
      .KEY_BITS    (KEY_BITS),
      .SIZE_BITS   (SIZE_BITS),
      .SEG_W       (SEG_W)
   ) u_store (
      .clock      (clock),
      .ctl        (mem_ctl),
      .rd_addr    (rd_addr),
      .ent_addr   (ent_addr),
      .ent_key    (ent_key),
      .ent_size   (ent_size),
      .ent_seg    (ent_seg),
      .older_addr (older_addr),
      .older_data (older_data),
      .newer_addr (newer_addr),
      .newer_data (newer_data),
      .rd_key     (rd_key),
      .rd_size    (rd_size),
      .rd_seg     (rd_seg),
      .rd_older   (rd_older),
      .rd_newer   (rd_newer)
   );

   // shared conditions
   logic                  req_fire, rsp_free, csr_fire;
   logic [NSEG_W-1:0]     nseg;
   logic                  scan_hit, scan_end, hit_up_ok, seg_up_ok;
   logic [CHG_W-1:0]      carry_chg, chg_sel;
   logic                  fits, cnt_nz, at_base, evict_done, any_nz, too_big;
   logic [SEG_W-1:0]      low_seg;

   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == slru_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      if (act_ff == '0) begin
         nseg = NSEG_W'(1);
      end else if (32'(act_ff) > MAX_SEGMENTS) begin
         nseg = NSEG_W'(MAX_SEGMENTS);
      end else begin
         nseg = NSEG_W'(act_ff);
      end
   end

   assign scan_hit  = cmp_vld_ff && valid_ff[cmp_addr_ff] && (rd_key == key_ff);
   assign scan_end  = cmp_vld_ff && (cmp_addr_ff == IDX_W'(N - 1));
   assign hit_up_ok = (NSEG_W'(rd_seg) + NSEG_W'(1)) < nseg;
   assign seg_up_ok = (NSEG_W'(seg_ff) + NSEG_W'(1)) < nseg;
   assign carry_chg = CHG_W'(csize_ff[seg_ff]) + CHG_W'(meta_ff);
   assign chg_sel   = (state_ff == slru_pkg::ST_CHECK) ? carry_chg : chg_ff;
   assign cnt_nz    = (cnt_ff[seg_ff] != '0);
   assign fits      = (32'(cnt_ff[seg_ff]) < ENTRIES_PER_SEGMENT) &&
                      ((CMP_W'(used_ff[seg_ff]) + CMP_W'(chg_sel)) <= CMP_W'(segb_ff));
   assign at_base   = (seg_ff == base_ff);
   assign too_big   = CMP_W'(chg_ff) > CMP_W'(segb_ff);

   always_comb begin
      any_nz  = 1'b0;
      low_seg = '0;
      for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
         if (cnt_ff[i] != '0) begin
            any_nz  = 1'b1;
            low_seg = SEG_W'(i);
         end
      end
   end

   assign evict_done = !any_nz || ((CMP_W'(total_ff) + CMP_W'(chg_ff)) <= CMP_W'(cap_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slru_pkg::ST_IDLE: begin
            if (req_fire) state_in = slru_pkg::ST_SCAN;
         end
         slru_pkg::ST_SCAN: begin
            if (scan_hit) begin
               if (op_ff == slru_pkg::OP_REMOVE || hit_up_ok) state_in = slru_pkg::ST_UNL_RD;
               else state_in = slru_pkg::ST_DONE;
            end else if (scan_end) begin
               if (op_ff == slru_pkg::OP_REMOVE || too_big) state_in = slru_pkg::ST_DONE;
               else state_in = slru_pkg::ST_EVICT;
            end
         end
         slru_pkg::ST_UNL_RD: state_in = slru_pkg::ST_UNL_WR;
         slru_pkg::ST_UNL_WR: begin
            unique case (ctx_ff)
               slru_pkg::CTX_REMOVE:  state_in = slru_pkg::ST_DONE;
               slru_pkg::CTX_PROMOTE: state_in = slru_pkg::ST_CHECK;
               slru_pkg::CTX_COOL:    state_in = slru_pkg::ST_CHECK;
               slru_pkg::CTX_EVICT:   state_in = slru_pkg::ST_EVICT;
               slru_pkg::CTX_FIT0:    state_in = slru_pkg::ST_FIT0;
               default:               state_in = slru_pkg::ST_DONE;
            endcase
         end
         slru_pkg::ST_CHECK: begin
            if (!fits && cnt_nz) state_in = slru_pkg::ST_UNL_RD;
            else if (at_base) state_in = slru_pkg::ST_DONE;
         end
         slru_pkg::ST_EVICT: begin
            if (evict_done) state_in = slru_pkg::ST_FIT;
            else state_in = slru_pkg::ST_UNL_RD;
         end
         slru_pkg::ST_FIT: begin
            if (fits) state_in = slru_pkg::ST_DONE;
            else if (!seg_up_ok) state_in = slru_pkg::ST_FIT0;
         end
         slru_pkg::ST_FIT0: begin
            if (fits || !cnt_nz) state_in = slru_pkg::ST_DONE;
            else state_in = slru_pkg::ST_UNL_RD;
         end
         slru_pkg::ST_DONE: begin
            if (rsp_free) state_in = slru_pkg::ST_IDLE;
         end
         default: state_in = slru_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   logic                 do_link, do_drop, lk_nz, is_lru, is_mru;
   logic [IDX_W-1:0]     lk_slot;
   logic [KEY_BITS-1:0]  lk_key;
   logic [SIZE_BITS-1:0] lk_size;
   logic [CHG_W-1:0]     lk_chg, st_chg;
   logic [USED_W-1:0]    dec;

   assign st_chg = CHG_W'(rd_size) + CHG_W'(meta_ff);
   assign is_lru = (u_ff == lru_ff[seg_ff]);
   assign is_mru = (u_ff == mru_ff[seg_ff]);
   assign dec    = (used_ff[seg_ff] >= USED_W'(st_chg)) ? USED_W'(st_chg) : used_ff[seg_ff];

   always_comb begin
      segb_in     = segb_ff;
      meta_in     = meta_ff;
      act_in      = act_ff;
      ctx_in      = ctx_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      size_in     = size_ff;
      chg_in      = chg_ff;
      cap_in      = cap_ff;
      scan_in     = scan_ff;
      cmp_vld_in  = 1'b0;
      cmp_addr_in = cmp_addr_ff;
      free_in     = free_ff;
      hit_in      = hit_ff;
      hit_seg_in  = hit_seg_ff;
      hit_idx_in  = hit_idx_ff;
      ins_in      = ins_ff;
      ins_seg_in  = ins_seg_ff;
      big_in      = big_ff;
      drop_in     = drop_ff;
      seg_in      = seg_ff;
      base_in     = base_ff;
      u_in        = u_ff;
      cnt_in      = cnt_ff;
      used_in     = used_ff;
      lru_in      = lru_ff;
      mru_in      = mru_ff;
      total_in    = total_ff;
      valid_in    = valid_ff;
      cslot_in    = cslot_ff;
      ckey_in     = ckey_ff;
      csize_in    = csize_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      rd_addr    = '0;
      mem_ctl    = '0;
      ent_addr   = '0;
      ent_key    = '0;
      ent_size   = '0;
      ent_seg    = seg_ff;
      older_addr = '0;
      older_data = '0;
      newer_addr = '0;
      newer_data = '0;

      do_link = 1'b0;
      do_drop = 1'b0;
      lk_slot = free_ff;
      lk_key  = key_ff;
      lk_size = size_ff;
      lk_nz   = cnt_nz;
      lk_chg  = chg_sel;

      unique case (state_ff)
         slru_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_tuser[0];
               key_in  = KEY_BITS'(req_tdata[slru_pkg::ID_W-1:0]);
               size_in = SIZE_BITS'(req_tdata[slru_pkg::REQ_DATA_W-1:slru_pkg::ID_W]);
               chg_in  = CHG_W'(SIZE_BITS'(req_tdata[slru_pkg::REQ_DATA_W-1:slru_pkg::ID_W]))
                         + CHG_W'(meta_ff);
               cap_in  = TOT_W'(segb_ff) * TOT_W'(nseg);
               scan_in = '0;
               hit_in  = 1'b0;
               hit_seg_in = '0;
               ins_in  = 1'b0;
               ins_seg_in = '0;
               big_in  = 1'b0;
               drop_in = '0;
            end
         end
         slru_pkg::ST_SCAN: begin
            rd_addr = scan_ff[IDX_W-1:0];
            if (cmp_vld_ff && !valid_ff[cmp_addr_ff]) free_in = cmp_addr_ff;
            if (scan_hit) begin
               hit_in     = 1'b1;
               hit_seg_in = rd_seg;
               hit_idx_in = cmp_addr_ff;
               seg_in     = rd_seg;
               ctx_in     = (op_ff == slru_pkg::OP_REMOVE) ? slru_pkg::CTX_REMOVE
                                                           : slru_pkg::CTX_PROMOTE;
            end else if (scan_end) begin
               if (op_ff == slru_pkg::OP_ACCESS && too_big) big_in = 1'b1;
            end else if (32'(scan_ff) < N) begin
               cmp_vld_in  = 1'b1;
               cmp_addr_in = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + 1'b1;
            end
         end
         slru_pkg::ST_UNL_RD: begin
            if (ctx_ff == slru_pkg::CTX_REMOVE || ctx_ff == slru_pkg::CTX_PROMOTE) begin
               rd_addr = hit_idx_ff;
            end else begin
               rd_addr = lru_ff[seg_ff];
            end
            u_in = rd_addr;
         end
         slru_pkg::ST_UNL_WR: begin
            // splice the entry out of its segment list
            if (!is_lru && !is_mru) begin
               mem_ctl.older_we = 1'b1;
               older_addr       = rd_newer;
               older_data       = rd_older;
               mem_ctl.newer_we = 1'b1;
               newer_addr       = rd_older;
               newer_data       = rd_newer;
            end else if (is_lru && !is_mru) begin
               lru_in[seg_ff] = rd_newer;
            end else if (is_mru && !is_lru) begin
               mru_in[seg_ff] = rd_older;
            end
            valid_in[u_ff]  = 1'b0;
            if (cnt_nz) cnt_in[seg_ff] = cnt_ff[seg_ff] - 1'b1;
            used_in[seg_ff] = used_ff[seg_ff] - dec;
            total_in        = total_ff - TOT_W'(dec);
            unique case (ctx_ff)
               slru_pkg::CTX_REMOVE: begin
               end
               slru_pkg::CTX_PROMOTE: begin
                  cslot_in[SEG_W'(seg_ff + 1'b1)] = hit_idx_ff;
                  ckey_in[SEG_W'(seg_ff + 1'b1)]  = key_ff;
                  csize_in[SEG_W'(seg_ff + 1'b1)] = size_ff;
                  seg_in  = SEG_W'(seg_ff + 1'b1);
                  base_in = SEG_W'(seg_ff + 1'b1);
               end
               slru_pkg::CTX_COOL: begin
                  if (seg_ff == '0) begin
                     do_drop = 1'b1;
                     free_in = u_ff;
                  end else begin
                     cslot_in[SEG_W'(seg_ff - 1'b1)] = u_ff;
                     ckey_in[SEG_W'(seg_ff - 1'b1)]  = rd_key;
                     csize_in[SEG_W'(seg_ff - 1'b1)] = rd_size;
                     seg_in = SEG_W'(seg_ff - 1'b1);
                  end
               end
               slru_pkg::CTX_EVICT, slru_pkg::CTX_FIT0: begin
                  do_drop = 1'b1;
                  free_in = u_ff;
               end
               default: begin
               end
            endcase
         end
         slru_pkg::ST_CHECK: begin
            lk_slot = cslot_ff[seg_ff];
            lk_key  = ckey_ff[seg_ff];
            lk_size = csize_ff[seg_ff];
            if (fits) begin
               do_link = 1'b1;
               if (!at_base) seg_in = SEG_W'(seg_ff + 1'b1);
            end else if (cnt_nz) begin
               ctx_in = slru_pkg::CTX_COOL;
            end else begin
               // target empty and still too small: the object leaves the cache
               do_drop = 1'b1;
               if (!at_base) seg_in = SEG_W'(seg_ff + 1'b1);
            end
         end
         slru_pkg::ST_EVICT: begin
            if (evict_done) begin
               seg_in = '0;
            end else begin
               seg_in = low_seg;
               ctx_in = slru_pkg::CTX_EVICT;
            end
         end
         slru_pkg::ST_FIT: begin
            if (fits) begin
               do_link    = 1'b1;
               ins_in     = 1'b1;
               ins_seg_in = seg_ff;
            end else if (seg_up_ok) begin
               seg_in = SEG_W'(seg_ff + 1'b1);
            end else begin
               seg_in = '0;
            end
         end
         slru_pkg::ST_FIT0: begin
            if (fits || !cnt_nz) begin
               do_link    = 1'b1;
               ins_in     = 1'b1;
               ins_seg_in = seg_ff;
            end else begin
               ctx_in = slru_pkg::CTX_FIT0;
            end
         end
         slru_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {big_in, drop_ff, 2'(ins_seg_ff), ins_ff, 2'(hit_seg_ff), hit_ff};
            end
         end
         default: begin
         end
      endcase

      if (do_drop) drop_in = drop_ff + 1'b1;

      // insert at the MRU end of segment seg_ff
      if (do_link) begin
         mem_ctl.ent_we   = 1'b1;
         ent_addr         = lk_slot;
         ent_key          = lk_key;
         ent_size         = lk_size;
         mem_ctl.older_we = 1'b1;
         older_addr       = lk_slot;
         older_data       = mru_ff[seg_ff];
         if (lk_nz) begin
            mem_ctl.newer_we = 1'b1;
            newer_addr       = mru_ff[seg_ff];
            newer_data       = lk_slot;
         end else begin
            lru_in[seg_ff] = lk_slot;
         end
         mru_in[seg_ff]    = lk_slot;
         valid_in[lk_slot] = 1'b1;
         cnt_in[seg_ff]    = cnt_ff[seg_ff] + 1'b1;
         used_in[seg_ff]   = used_ff[seg_ff] + USED_W'(lk_chg);
         total_in          = total_ff + TOT_W'(lk_chg);
      end

      // any register write empties the cache
      if (csr_fire) begin
         if (csr_index == slru_pkg::CSR_SEGMENT_BYTES ||
             csr_index == slru_pkg::CSR_METADATA_BYTES ||
             csr_index == slru_pkg::CSR_ACTIVE_SEGMENTS) begin
            if (csr_index == slru_pkg::CSR_SEGMENT_BYTES) segb_in = csr_data;
            if (csr_index == slru_pkg::CSR_METADATA_BYTES) meta_in = slru_pkg::META_W'(csr_data);
            if (csr_index == slru_pkg::CSR_ACTIVE_SEGMENTS) act_in = slru_pkg::ACT_W'(csr_data);
            valid_in = '0;
            total_in = '0;
            for (int i = 0; i < MAX_SEGMENTS; i++) begin
               cnt_in[i]  = '0;
               used_in[i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slru_pkg::ST_IDLE;
         ctx_ff       <= slru_pkg::CTX_REMOVE;
         segb_ff      <= slru_pkg::SEGMENT_BYTES_RST;
         meta_ff      <= slru_pkg::METADATA_BYTES_RST;
         act_ff       <= slru_pkg::ACTIVE_SEGMENTS_RST;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_SEGMENTS; i++) begin
            cnt_ff[i]  <= '0;
            used_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ctx_ff       <= ctx_in;
         segb_ff      <= segb_in;
         meta_ff      <= meta_in;
         act_ff       <= act_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      size_ff     <= size_in;
      chg_ff      <= chg_in;
      cap_ff      <= cap_in;
      scan_ff     <= scan_in;
      cmp_addr_ff <= cmp_addr_in;
      free_ff     <= free_in;
      hit_ff      <= hit_in;
      hit_seg_ff  <= hit_seg_in;
      hit_idx_ff  <= hit_idx_in;
      ins_ff      <= ins_in;
      ins_seg_ff  <= ins_seg_in;
      big_ff      <= big_in;
      drop_ff     <= drop_in;
      seg_ff      <= seg_in;
      base_ff     <= base_in;
      u_ff        <= u_in;
      lru_ff      <= lru_in;
      mru_ff      <= mru_in;
      cslot_ff    <= cslot_in;
      ckey_ff     <= ckey_in;
      csize_ff    <= csize_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
